// ===== sv/pts_pkg.sv =====
// shared types and constants for the pan/tilt slew controller
`default_nettype none

package pts_pkg;

   localparam int CFG_BITS = 10;
   localparam int CSR_INDEX_BITS = 3;

   // item opcodes
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_SET  = 2'd1;
   localparam logic [1:0] OP_HOME = 2'd2;

   // motion codes reported per axis
   localparam logic [1:0] MOTION_NONE = 2'd0;
   localparam logic [1:0] MOTION_LEFT = 2'd1;
   localparam logic [1:0] MOTION_RIGHT = 2'd2;
   localparam logic [1:0] MOTION_UP = 2'd1;
   localparam logic [1:0] MOTION_DOWN = 2'd2;

   // direction flag positions
   localparam int DIR_LEFT_BIT  = 0;
   localparam int DIR_UP_BIT    = 1;
   localparam int DIR_RIGHT_BIT = 2;
   localparam int DIR_DOWN_BIT  = 3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAN_MIN    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAN_MAX    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PITCH_MIN  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PITCH_MAX  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAN_HOME   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PITCH_HOME = 3'd5;

   // register reset values
   localparam logic [CFG_BITS-1:0] PAN_MIN_RESET    = 10'd0;
   localparam logic [CFG_BITS-1:0] PAN_MAX_RESET    = 10'd360;
   localparam logic [CFG_BITS-1:0] PITCH_MIN_RESET  = 10'd0;
   localparam logic [CFG_BITS-1:0] PITCH_MAX_RESET  = 10'd360;
   localparam logic [CFG_BITS-1:0] PAN_HOME_RESET   = 10'd180;
   localparam logic [CFG_BITS-1:0] PITCH_HOME_RESET = 10'd180;

   typedef struct packed {
      logic [1:0]          op;
      logic [CFG_BITS-1:0] goal_pan;
      logic [CFG_BITS-1:0] goal_pitch;
   } req_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] pan_position;
      logic [CFG_BITS-1:0] pitch_position;
      logic [1:0]          pan_motion;
      logic [1:0]          pitch_motion;
   } rsp_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] pan_min;
      logic [CFG_BITS-1:0] pan_max;
      logic [CFG_BITS-1:0] pitch_min;
      logic [CFG_BITS-1:0] pitch_max;
      logic [CFG_BITS-1:0] pan_home;
      logic [CFG_BITS-1:0] pitch_home;
   } cfg_type;

endpackage

`default_nettype wire

// ===== sv/pts_csr.sv =====
// configuration register file for the pan/tilt slew controller
`default_nettype none

module pts_csr
   import pts_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]       csr_data,
   output cfg_type                        cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PAN_MIN:    cfg_in.pan_min = csr_data;
            CSR_PAN_MAX:    cfg_in.pan_max = csr_data;
            CSR_PITCH_MIN:  cfg_in.pitch_min = csr_data;
            CSR_PITCH_MAX:  cfg_in.pitch_max = csr_data;
            CSR_PAN_HOME:   cfg_in.pan_home = csr_data;
            CSR_PITCH_HOME: cfg_in.pitch_home = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pan_min    <= PAN_MIN_RESET;
         cfg_ff.pan_max    <= PAN_MAX_RESET;
         cfg_ff.pitch_min  <= PITCH_MIN_RESET;
         cfg_ff.pitch_max  <= PITCH_MAX_RESET;
         cfg_ff.pan_home   <= PAN_HOME_RESET;
         cfg_ff.pitch_home <= PITCH_HOME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/pts_core.sv =====
// axis state, slew step and result register of the pan/tilt slew controller
`default_nettype none

module pts_core
   import pts_pkg::*;
#(
   parameter int POS_BITS = 10
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // compare width covers both positions and limit registers plus a carry
   localparam int CW = ((POS_BITS > CFG_BITS) ? POS_BITS : CFG_BITS) + 1;

   logic [POS_BITS-1:0] pan_pos_ff, pan_pos_in;
   logic [POS_BITS-1:0] pitch_pos_ff, pitch_pos_in;
   logic [POS_BITS-1:0] pan_goal_ff, pan_goal_in;
   logic [POS_BITS-1:0] pitch_goal_ff, pitch_goal_in;
   logic [3:0]          dir_ff, dir_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                accept;
   logic [POS_BITS-1:0] aim_pan, aim_pitch;
   logic [CW-1:0]       pan_x, pitch_x, aim_pan_x, aim_pitch_x;
   logic [CW-1:0]       pan_min_x, pan_max_x, pitch_min_x, pitch_max_x;
   logic [CW-1:0]       one_x;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign one_x = CW'(1);
   assign pan_x = CW'(pan_pos_ff);
   assign pitch_x = CW'(pitch_pos_ff);
   assign pan_min_x = CW'(cfg.pan_min);
   assign pan_max_x = CW'(cfg.pan_max);
   assign pitch_min_x = CW'(cfg.pitch_min);
   assign pitch_max_x = CW'(cfg.pitch_max);

   // goals come from the item or from the home registers
   assign aim_pan = (req_data.op == OP_SET) ? POS_BITS'(req_data.goal_pan)
                                            : POS_BITS'(cfg.pan_home);
   assign aim_pitch = (req_data.op == OP_SET) ? POS_BITS'(req_data.goal_pitch)
                                              : POS_BITS'(cfg.pitch_home);
   assign aim_pan_x = CW'(aim_pan);
   assign aim_pitch_x = CW'(aim_pitch);

   always_comb begin
      pan_pos_in = pan_pos_ff;
      pitch_pos_in = pitch_pos_ff;
      pan_goal_in = pan_goal_ff;
      pitch_goal_in = pitch_goal_ff;
      dir_in = dir_ff;
      case (req_data.op) inside
         OP_TICK: begin
            if (dir_ff != 4'd0) begin
               if (dir_ff[DIR_LEFT_BIT]) begin
                  if (pan_x >= pan_min_x + one_x) begin
                     pan_pos_in = POS_BITS'(pan_x - one_x);
                  end else begin
                     pan_pos_in = POS_BITS'(pan_min_x);
                  end
               end else if (dir_ff[DIR_RIGHT_BIT]) begin
                  if (pan_x + one_x <= pan_max_x) begin
                     pan_pos_in = POS_BITS'(pan_x + one_x);
                  end else begin
                     pan_pos_in = POS_BITS'(pan_max_x);
                  end
               end
               // pitch only moves toward the inside of its limits
               if (dir_ff[DIR_UP_BIT]) begin
                  if (pitch_x < pitch_max_x) begin
                     pitch_pos_in = pitch_pos_ff + 1'b1;
                  end
               end else if (dir_ff[DIR_DOWN_BIT]) begin
                  if (pitch_x > pitch_min_x) begin
                     pitch_pos_in = pitch_pos_ff - 1'b1;
                  end
               end
               // arrival, checked on both axes; a zero goal never arrives
               if (pan_goal_ff != '0 && pan_pos_in == pan_goal_ff) begin
                  dir_in[DIR_LEFT_BIT] = 1'b0;
                  dir_in[DIR_RIGHT_BIT] = 1'b0;
                  pan_goal_in = '0;
               end
               if (pitch_goal_ff != '0 && pitch_pos_in == pitch_goal_ff) begin
                  dir_in[DIR_UP_BIT] = 1'b0;
                  dir_in[DIR_DOWN_BIT] = 1'b0;
                  pitch_goal_in = '0;
               end
            end
         end
         OP_SET, OP_HOME: begin
            pan_goal_in = aim_pan;
            pitch_goal_in = aim_pitch;
            dir_in = 4'd0;
            if (pan_x > aim_pan_x + one_x) begin
               dir_in[DIR_LEFT_BIT] = 1'b1;
            end else if (pan_x + one_x < aim_pan_x) begin
               dir_in[DIR_RIGHT_BIT] = 1'b1;
            end
            if (pitch_x + one_x < aim_pitch_x) begin
               dir_in[DIR_UP_BIT] = 1'b1;
            end else if (pitch_x > aim_pitch_x + one_x) begin
               dir_in[DIR_DOWN_BIT] = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_in.pan_position = CFG_BITS'(pan_pos_in);
      rsp_in.pitch_position = CFG_BITS'(pitch_pos_in);
      rsp_in.pan_motion = dir_in[DIR_LEFT_BIT] ? MOTION_LEFT :
                          (dir_in[DIR_RIGHT_BIT] ? MOTION_RIGHT : MOTION_NONE);
      rsp_in.pitch_motion = dir_in[DIR_UP_BIT] ? MOTION_UP :
                            (dir_in[DIR_DOWN_BIT] ? MOTION_DOWN : MOTION_NONE);
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_pos_ff <= '0;
         pitch_pos_ff <= '0;
         pan_goal_ff <= '0;
         pitch_goal_ff <= '0;
         dir_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            pan_pos_ff <= pan_pos_in;
            pitch_pos_ff <= pitch_pos_in;
            pan_goal_ff <= pan_goal_in;
            pitch_goal_ff <= pitch_goal_in;
            dir_ff <= dir_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   a_pan_one_dir: assert property (@(posedge clock) disable iff (reset)
      !(dir_ff[DIR_LEFT_BIT] && dir_ff[DIR_RIGHT_BIT]))
      else $error("pan moving both ways");

   a_pitch_one_dir: assert property (@(posedge clock) disable iff (reset)
      !(dir_ff[DIR_UP_BIT] && dir_ff[DIR_DOWN_BIT]))
      else $error("pitch moving both ways");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item left no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while result held");

   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.op == OP_TICK && dir_ff == 4'd0)
      |=> ($stable(pan_pos_ff) && $stable(pitch_pos_ff)))
      else $error("idle tick moved an axis");

endmodule

`default_nettype wire

// ===== sv/pan_tilt_slew_controller_top.sv =====
// top level of the pan/tilt slew controller
`default_nettype none

// Two-axis pan/tilt slew controller. Each req_ item is a tick (step every
// axis with a latched direction by one half-degree unit), a set-goal command
// or a home command; each item yields exactly one rsp_ item holding both
// positions and both latched directions after the item is applied. Rate is
// one item per clock unless a result is held: the whole update is a single
// compare/increment pass on the axis registers, and the result sits in a
// one-deep output register, so req_ready stays high while that register is
// empty or being drained. The csr_ port is always ready and registers each
// write; writes should only come while no item is in flight.
module pan_tilt_slew_controller_top
   import pts_pkg::*;
#(
   parameter int POS_BITS = 10
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // item input
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire req_type                   req_data,
   // result output
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output rsp_type                        rsp_data,
   // register writes
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]       csr_data
);

   // limits and home goals from the register file
   cfg_type cfg;

   pts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // axis state and result register
   pts_core #(
      .POS_BITS (POS_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
